/* hw/rtl/sip_pkg.sv */
// Shared constants and types for the segment intersection point unit.
`default_nettype none

package sip_pkg;

  localparam int CoordFracBits = 16;
  localparam int ParamFracBits = 24;

  localparam int CrossTolW = 20;
  localparam int ParamTolW = 16;
  localparam int CfgDataW  = 20;
  localparam int CfgIndexW = 1;

  localparam logic [CrossTolW-1:0] CrossTolReset = CrossTolW'(429);
  localparam logic [ParamTolW-1:0] ParamTolReset = ParamTolW'(2);

  localparam logic [CfgIndexW-1:0] CfgCrossTol = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgParamTol = 1'b1;

  typedef enum logic [1:0] {
    ST_INTERSECT = 2'd0,
    ST_COLLINEAR = 2'd1,
    ST_PARALLEL  = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_e;

endpackage

`default_nettype wire

/* hw/rtl/segment_intersection_point_unit.sv */
// Top level of the segment intersection point unit: pipeline, divider and register file.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   eight endpoint coordinates
//  m_axis    out        m_axis_tvalid/m_axis_tready   status, cross_x, cross_y
//  cfg       in         cfg_valid_i/cfg_ready_o       register index, write data
//
// One segment pair enters per cycle unless the output stalls. Stages A to C, the
// long division (Q+2 quotient bits, Q = max(PARAM_FRAC_BITS, 16), two a stage) and
// D to F follow in order. Each stage holds its item while the next one is full,
// so a stalled output backs up stage by stage and bubbles close up; nothing is lost.
// Reset clears every valid bit and loads the tolerance registers with their defaults.
`default_nettype none

module segment_intersection_point_unit import sip_pkg::*; #(
  parameter int COORD_FRAC_BITS = CoordFracBits,
  parameter int PARAM_FRAC_BITS = ParamFracBits,
  localparam int InW  = (((COORD_FRAC_BITS + 1) * 8 + 7) / 8) * 8,
  localparam int OutW = ((2 + 2 * (COORD_FRAC_BITS + 1) + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y (lowest first)
  input  logic [InW-1:0]       s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status, cross_x, cross_y (lowest first), zero padded
  output logic [OutW-1:0]      m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int CW     = COORD_FRAC_BITS + 1;       // coordinate
  localparam int DW     = COORD_FRAC_BITS + 2;       // signed difference
  localparam int PW     = 2 * DW;                    // signed product and cross sum
  localparam int MagW   = PW - 1;                    // cross magnitude
  localparam int QBits  = ((PARAM_FRAC_BITS > ParamTolW) ? PARAM_FRAC_BITS : ParamTolW) + 2;
  localparam int TW     = QBits + 1;                 // signed parameter t
  localparam int MW     = TW + DW;                   // t times delta
  localparam int AccW   = QBits + COORD_FRAC_BITS + 4;
  localparam int VW     = AccW - PARAM_FRAC_BITS;

  localparam logic [QBits:0]          ParamOne = (QBits + 1)'(1) << PARAM_FRAC_BITS;
  localparam logic signed [AccW-1:0]  Half     = AccW'(1) << (PARAM_FRAC_BITS - 1);
  localparam logic [VW-1:0]           CoordOne = VW'(1) << COORD_FRAC_BITS;

  typedef struct packed {
    logic [CW-1:0]        px;
    logic [CW-1:0]        py;
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    status_e              status;
    logic                 neg_t;
    logic                 neg_u;
  } side_t;

  // ---------------- configuration registers ----------------
  logic [CrossTolW-1:0] cross_tol_q;
  logic [ParamTolW-1:0] param_tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_tol_q <= CrossTolReset;
      param_tol_q <= ParamTolReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCrossTol: cross_tol_q <= cfg_data_i[CrossTolW-1:0];
        CfgParamTol: param_tol_q <= cfg_data_i[ParamTolW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stall chain ----------------
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q, f_vld_q;
  logic a_en, b_en, c_en, d_en, e_en, f_en;
  logic div_in_ready, div_out_valid;

  assign f_en = !f_vld_q || m_axis_tready;
  assign e_en = !e_vld_q || f_en;
  assign d_en = !d_vld_q || e_en;
  assign c_en = !c_vld_q || div_in_ready;
  assign b_en = !b_vld_q || c_en;
  assign a_en = !a_vld_q || b_en;

  assign s_axis_tready = a_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else begin
      if (a_en) a_vld_q <= s_axis_tvalid;
      if (b_en) b_vld_q <= a_vld_q;
      if (c_en) c_vld_q <= b_vld_q;
      if (d_en) d_vld_q <= div_out_valid;
      if (e_en) e_vld_q <= d_vld_q;
      if (f_en) f_vld_q <= e_vld_q;
    end
  end

  // ---------------- stage A: differences ----------------
  logic [CW-1:0] in_c [8];
  for (genvar i = 0; i < 8; i++) begin : g_field
    assign in_c[i] = s_axis_tdata[i*CW +: CW];
  end

  logic [CW-1:0]        a_px_q, a_py_q;
  logic signed [DW-1:0] a_rx_q, a_ry_q, a_sx_q, a_sy_q, a_dx_q, a_dy_q;

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_px_q <= in_c[0];
      a_py_q <= in_c[1];
      a_rx_q <= $signed({1'b0, in_c[2]}) - $signed({1'b0, in_c[0]});
      a_ry_q <= $signed({1'b0, in_c[3]}) - $signed({1'b0, in_c[1]});
      a_sx_q <= $signed({1'b0, in_c[6]}) - $signed({1'b0, in_c[4]});
      a_sy_q <= $signed({1'b0, in_c[7]}) - $signed({1'b0, in_c[5]});
      a_dx_q <= $signed({1'b0, in_c[4]}) - $signed({1'b0, in_c[0]});
      a_dy_q <= $signed({1'b0, in_c[5]}) - $signed({1'b0, in_c[1]});
    end
  end

  // ---------------- stage B: cross-product terms ----------------
  logic [CW-1:0]        b_px_q, b_py_q;
  logic signed [DW-1:0] b_rx_q, b_ry_q;
  logic signed [PW-1:0] b_rxsy_q, b_rysx_q, b_dxry_q, b_dyrx_q, b_dxsy_q, b_dysx_q;

  always_ff @(posedge clk_i) begin
    if (b_en) begin
      b_px_q   <= a_px_q;
      b_py_q   <= a_py_q;
      b_rx_q   <= a_rx_q;
      b_ry_q   <= a_ry_q;
      b_rxsy_q <= PW'(a_rx_q) * PW'(a_sy_q);
      b_rysx_q <= PW'(a_ry_q) * PW'(a_sx_q);
      b_dxry_q <= PW'(a_dx_q) * PW'(a_ry_q);
      b_dyrx_q <= PW'(a_dy_q) * PW'(a_rx_q);
      b_dxsy_q <= PW'(a_dx_q) * PW'(a_sy_q);
      b_dysx_q <= PW'(a_dy_q) * PW'(a_sx_q);
    end
  end

  // ---------------- stage C: cross sums, tolerance test ----------------
  logic signed [PW-1:0] rxs, qpxr, qpxs;
  logic [MagW-1:0]      mag_rxs, mag_qpxr, mag_qpxs;
  logic                 rxs_small, qpxr_small;
  side_t                c_side_d, c_side_q;
  logic [MagW-1:0]      c_den_q, c_num_t_q, c_num_u_q;

  always_comb begin
    rxs  = b_rxsy_q - b_rysx_q;
    qpxr = b_dxry_q - b_dyrx_q;
    qpxs = b_dxsy_q - b_dysx_q;
    mag_rxs  = rxs[PW-1]  ? MagW'(-rxs)  : MagW'(rxs);
    mag_qpxr = qpxr[PW-1] ? MagW'(-qpxr) : MagW'(qpxr);
    mag_qpxs = qpxs[PW-1] ? MagW'(-qpxs) : MagW'(qpxs);
    rxs_small  = {{CrossTolW{1'b0}}, mag_rxs}  <= {{MagW{1'b0}}, cross_tol_q};
    qpxr_small = {{CrossTolW{1'b0}}, mag_qpxr} <= {{MagW{1'b0}}, cross_tol_q};
    c_side_d.px    = b_px_q;
    c_side_d.py    = b_py_q;
    c_side_d.rx    = b_rx_q;
    c_side_d.ry    = b_ry_q;
    c_side_d.neg_t = qpxs[PW-1] ^ rxs[PW-1];
    c_side_d.neg_u = qpxr[PW-1] ^ rxs[PW-1];
    if (rxs_small) begin
      c_side_d.status = qpxr_small ? ST_COLLINEAR : ST_PARALLEL;
    end else begin
      c_side_d.status = ST_INTERSECT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_en) begin
      c_side_q  <= c_side_d;
      c_den_q   <= mag_rxs;
      c_num_t_q <= mag_qpxs;
      c_num_u_q <= mag_qpxr;
    end
  end

  // ---------------- divider: |t| and |u| ----------------
  logic [QBits-1:0] quo_t, quo_u;
  logic             ovf_t, ovf_u;
  side_t            div_side;

  sip_div #(
    .NumW     (MagW),
    .FracBits (PARAM_FRAC_BITS),
    .QBits    (QBits),
    .side_t   (side_t)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c_vld_q),
    .in_ready_o  (div_in_ready),
    .num_t_i     (c_num_t_q),
    .num_u_i     (c_num_u_q),
    .den_i       (c_den_q),
    .side_i      (c_side_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (d_en),
    .quo_t_o     (quo_t),
    .quo_u_o     (quo_u),
    .ovf_t_o     (ovf_t),
    .ovf_u_o     (ovf_u),
    .side_o      (div_side)
  );

  // ---------------- stage D: range test, signed t ----------------
  logic [QBits:0]       eps_ext, upper;
  logic                 t_in, u_in;
  status_e              d_status_d, d_status_q;
  logic signed [TW-1:0] d_t_q;
  logic [CW-1:0]        d_px_q, d_py_q;
  logic signed [DW-1:0] d_rx_q, d_ry_q;

  always_comb begin
    eps_ext = {{(QBits + 1 - ParamTolW){1'b0}}, param_tol_q};
    upper   = ParamOne + eps_ext;
    // negative side: |t| <= eps; positive side: t <= 1 + eps
    t_in = !ovf_t && (div_side.neg_t ? ({1'b0, quo_t} <= eps_ext) : ({1'b0, quo_t} <= upper));
    u_in = !ovf_u && (div_side.neg_u ? ({1'b0, quo_u} <= eps_ext) : ({1'b0, quo_u} <= upper));
    d_status_d = div_side.status;
    if (div_side.status == ST_INTERSECT && !(t_in && u_in)) d_status_d = ST_OUTSIDE;
  end

  always_ff @(posedge clk_i) begin
    if (d_en) begin
      d_status_q <= d_status_d;
      d_t_q      <= div_side.neg_t ? -$signed({1'b0, quo_t}) : $signed({1'b0, quo_t});
      d_px_q     <= div_side.px;
      d_py_q     <= div_side.py;
      d_rx_q     <= div_side.rx;
      d_ry_q     <= div_side.ry;
    end
  end

  // ---------------- stage E: t times r ----------------
  status_e              e_status_q;
  logic [CW-1:0]        e_px_q, e_py_q;
  logic signed [MW-1:0] e_tx_q, e_ty_q;

  always_ff @(posedge clk_i) begin
    if (e_en) begin
      e_status_q <= d_status_q;
      e_px_q     <= d_px_q;
      e_py_q     <= d_py_q;
      e_tx_q     <= MW'(d_t_q) * MW'(d_rx_q);
      e_ty_q     <= MW'(d_t_q) * MW'(d_ry_q);
    end
  end

  // ---------------- stage F: add, round, saturate ----------------
  logic signed [AccW-1:0] sum_x, sum_y;
  logic [CW-1:0]          pt_x, pt_y;
  logic [1:0]             f_status_q;
  logic [CW-1:0]          f_x_q, f_y_q;

  function automatic logic [CW-1:0] clamp_coord(input logic signed [AccW-1:0] v);
    logic [VW-1:0] w;
    w = VW'(v >>> PARAM_FRAC_BITS);
    if (v[AccW-1]) return '0;
    if (w > CoordOne) return CoordOne[CW-1:0];
    return w[CW-1:0];
  endfunction

  always_comb begin
    sum_x = $signed(AccW'(e_px_q) << PARAM_FRAC_BITS) + AccW'(e_tx_q) + Half;
    sum_y = $signed(AccW'(e_py_q) << PARAM_FRAC_BITS) + AccW'(e_ty_q) + Half;
    pt_x  = clamp_coord(sum_x);
    pt_y  = clamp_coord(sum_y);
  end

  always_ff @(posedge clk_i) begin
    if (f_en) begin
      f_status_q <= e_status_q;
      // no point unless the segments really cross
      f_x_q      <= (e_status_q == ST_INTERSECT) ? pt_x : '0;
      f_y_q      <= (e_status_q == ST_INTERSECT) ? pt_y : '0;
    end
  end

  assign m_axis_tvalid = f_vld_q;
  assign m_axis_tdata  = OutW'({f_y_q, f_x_q, f_status_q});

endmodule

`default_nettype wire

/* hw/rtl/sip_div.sv */
// Pipelined restoring divider: two numerators over one divisor, two quotient bits a stage.
`default_nettype none

module sip_div #(
  parameter int  NumW     = 35,
  parameter int  FracBits = 24,
  parameter int  QBits    = 26,
  parameter type side_t   = logic
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [NumW-1:0]   num_t_i,
  input  logic [NumW-1:0]   num_u_i,
  input  logic [NumW-1:0]   den_i,
  input  side_t             side_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [QBits-1:0]  quo_t_o,
  output logic [QBits-1:0]  quo_u_o,
  output logic              ovf_t_o,
  output logic              ovf_u_o,
  output side_t             side_o
);

  localparam int Shift  = QBits - FracBits;
  localparam int RemW   = NumW + Shift + 1;
  localparam int Stages = (QBits + 1) / 2;

  logic             vld_q     [Stages];
  logic             stage_en  [Stages];
  logic [RemW-1:0]  rem_t_q   [Stages];
  logic [RemW-1:0]  rem_u_q   [Stages];
  logic [RemW-1:0]  rem_t_d   [Stages];
  logic [RemW-1:0]  rem_u_d   [Stages];
  logic [QBits-1:0] quo_t_q   [Stages];
  logic [QBits-1:0] quo_u_q   [Stages];
  logic [QBits-1:0] quo_t_d   [Stages];
  logic [QBits-1:0] quo_u_d   [Stages];
  logic [RemW-1:0]  dv_q      [Stages];
  logic             ovf_t_q   [Stages];
  logic             ovf_u_q   [Stages];
  side_t            side_q    [Stages];

  logic             src_vld   [Stages];
  logic [RemW-1:0]  src_rem_t [Stages];
  logic [RemW-1:0]  src_rem_u [Stages];
  logic [QBits-1:0] src_quo_t [Stages];
  logic [QBits-1:0] src_quo_u [Stages];
  logic [RemW-1:0]  src_dv    [Stages];
  logic             src_ovf_t [Stages];
  logic             src_ovf_u [Stages];
  side_t            src_side  [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    if (k == 0) begin : g_src
      assign src_vld[k]   = in_valid_i;
      assign src_rem_t[k] = RemW'(num_t_i);
      assign src_rem_u[k] = RemW'(num_u_i);
      assign src_quo_t[k] = '0;
      assign src_quo_u[k] = '0;
      assign src_dv[k]    = RemW'(den_i) << Shift;
      // quotient would not fit in QBits: parameter is far out of range
      assign src_ovf_t[k] = RemW'(num_t_i) >= (RemW'(den_i) << Shift);
      assign src_ovf_u[k] = RemW'(num_u_i) >= (RemW'(den_i) << Shift);
      assign src_side[k]  = side_i;
    end else begin : g_src
      assign src_vld[k]   = vld_q[k-1];
      assign src_rem_t[k] = rem_t_q[k-1];
      assign src_rem_u[k] = rem_u_q[k-1];
      assign src_quo_t[k] = quo_t_q[k-1];
      assign src_quo_u[k] = quo_u_q[k-1];
      assign src_dv[k]    = dv_q[k-1];
      assign src_ovf_t[k] = ovf_t_q[k-1];
      assign src_ovf_u[k] = ovf_u_q[k-1];
      assign src_side[k]  = side_q[k-1];
    end
    if (k == Stages - 1) begin : g_en
      assign stage_en[k] = !vld_q[k] || out_ready_i;
    end else begin : g_en
      assign stage_en[k] = !vld_q[k] || stage_en[k+1];
    end
  end

  always_comb begin
    logic [RemW-1:0]  rt;
    logic [RemW-1:0]  ru;
    logic [QBits-1:0] qt;
    logic [QBits-1:0] qu;
    for (int k = 0; k < Stages; k++) begin
      rt = src_rem_t[k];
      ru = src_rem_u[k];
      qt = src_quo_t[k];
      qu = src_quo_u[k];
      for (int j = 0; j < 2; j++) begin
        if (2 * k + j < QBits) begin
          rt = rt << 1;
          qt = qt << 1;
          if (rt >= src_dv[k]) begin
            rt    = rt - src_dv[k];
            qt[0] = 1'b1;
          end
          ru = ru << 1;
          qu = qu << 1;
          if (ru >= src_dv[k]) begin
            ru    = ru - src_dv[k];
            qu[0] = 1'b1;
          end
        end
      end
      rem_t_d[k] = rt;
      rem_u_d[k] = ru;
      quo_t_d[k] = qt;
      quo_u_d[k] = qu;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Stages; k++) vld_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (stage_en[k]) vld_q[k] <= src_vld[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      if (stage_en[k]) begin
        rem_t_q[k] <= rem_t_d[k];
        rem_u_q[k] <= rem_u_d[k];
        quo_t_q[k] <= quo_t_d[k];
        quo_u_q[k] <= quo_u_d[k];
        dv_q[k]    <= src_dv[k];
        ovf_t_q[k] <= src_ovf_t[k];
        ovf_u_q[k] <= src_ovf_u[k];
        side_q[k]  <= src_side[k];
      end
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = vld_q[Stages-1];
  assign quo_t_o     = quo_t_q[Stages-1];
  assign quo_u_o     = quo_u_q[Stages-1];
  assign ovf_t_o     = ovf_t_q[Stages-1];
  assign ovf_u_o     = ovf_u_q[Stages-1];
  assign side_o      = side_q[Stages-1];

endmodule

`default_nettype wire

/* sim/tb.sv */
// Testbench for the segment intersection point unit: directed table, random pairs, self-check.
`default_nettype none

module tb;
  import sip_pkg::*;

  localparam int CW   = CoordFracBits + 1;
  localparam int InW  = CW * 8;
  localparam int OutW = ((2 + 2 * CW + 7) / 8) * 8;
  localparam longint unsigned CoordOne = 64'd1 << CoordFracBits;
  localparam longint unsigned CoordMax = (64'd1 << CW) - 1;
  localparam longint ParamOne = 64'sd1 << ParamFracBits;
  localparam longint unsigned MagCap = 64'd1 << 62;
  localparam int RandPerPhase = 380;

  // lowest bits first on m_axis: status, then x, then y
  typedef struct packed {
    logic [CW-1:0]   y;
    logic [CW-1:0]   x;
    status_e         status;
  } point_t;

  typedef struct {
    logic [InW-1:0] pair;
    bit             typed;
    point_t         want;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InW-1:0]       s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutW-1:0]      m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = CfgCrossTol;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  // Tolerances as the block holds them, tracked on each config transfer
  logic [CrossTolW-1:0] cross_tol = CrossTolReset;
  logic [ParamTolW-1:0] param_tol = ParamTolReset;

  point_t  points_due[$];   // expected results, oldest first
  bit      typed_due[$];    // per pair in flight on s_axis: typed expectation or not
  point_t  typed_point[$];
  int      errors = 0;
  bit      rx_hold_ready = 1'b0;

  segment_intersection_point_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Give up after a generous fixed time
  initial begin
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  // Signed quotient with ParamFracBits fraction bits, truncated, magnitude capped
  function automatic longint param_quotient(longint num, longint den);
    longint unsigned n, d, q0, r, frac, m;
    n = mag(num);
    d = mag(den);
    q0 = n / d;
    r = n % d;
    frac = 0;
    for (int i = 0; i < ParamFracBits; i++) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= d) begin
        r = r - d;
        frac = frac | 1;
      end
    end
    if (q0 >= (64'd1 << (62 - ParamFracBits))) m = MagCap;
    else m = (q0 << ParamFracBits) | frac;
    return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // base + t*delta, round half up, clamp to 0..1.0
  function automatic logic [CW-1:0] place_coord(longint base, longint t, longint delta);
    longint total;
    longint unsigned v;
    total = (base <<< ParamFracBits) + t * delta + (64'sd1 <<< (ParamFracBits - 1));
    if (total < 0) return '0;
    v = longint'(total) >> ParamFracBits;
    return (v > CoordOne) ? CW'(CoordOne) : CW'(v);
  endfunction

  function automatic point_t predict_point(logic [InW-1:0] pair);
    longint px, py, rx, ry, qx, qy, sx, sy, dx, dy, rxs, qpxr, qpxs, t, u, eps;
    point_t res;
    px = pair[0*CW +: CW];
    py = pair[1*CW +: CW];
    rx = longint'(pair[2*CW +: CW]) - px;
    ry = longint'(pair[3*CW +: CW]) - py;
    qx = pair[4*CW +: CW];
    qy = pair[5*CW +: CW];
    sx = longint'(pair[6*CW +: CW]) - qx;
    sy = longint'(pair[7*CW +: CW]) - qy;
    dx = qx - px;
    dy = qy - py;
    rxs  = rx * sy - ry * sx;
    qpxr = dx * ry - dy * rx;
    qpxs = dx * sy - dy * sx;
    eps = param_tol;
    res = '{status: ST_INTERSECT, x: '0, y: '0};
    if (mag(rxs) <= cross_tol) begin
      res.status = (mag(qpxr) <= cross_tol) ? ST_COLLINEAR : ST_PARALLEL;
      return res;
    end
    t = param_quotient(qpxs, rxs);
    u = param_quotient(qpxr, rxs);
    if (t < -eps || t > ParamOne + eps || u < -eps || u > ParamOne + eps) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    res.x = place_coord(px, t, rx);
    res.y = place_coord(py, t, ry);
    return res;
  endfunction

  function automatic logic [InW-1:0] pack_pair(longint unsigned a0, a1, a2, a3,
                                               longint unsigned b0, b1, b2, b3);
    return {CW'(b3), CW'(b2), CW'(b1), CW'(b0), CW'(a3), CW'(a2), CW'(a1), CW'(a0)};
  endfunction

  // Mostly the nominal 0..1.0 range, sometimes the full field, sometimes the edges
  function automatic longint unsigned rand_coord();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 0;
    if (sel == 1) return CoordOne;
    if (sel == 2) return CoordMax;
    if (sel < 5) return $urandom_range(0, int'(CoordMax));
    return $urandom_range(0, int'(CoordOne));
  endfunction

  // Random pair, biased towards shapes that reach every status
  function automatic logic [InW-1:0] rand_pair();
    longint unsigned c[8];
    int sel;
    for (int i = 0; i < 8; i++) c[i] = rand_coord();
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin            // all on one horizontal line
        c[3] = c[1]; c[5] = c[1]; c[7] = c[1];
      end
      1: begin            // two horizontal lines
        c[3] = c[1]; c[7] = c[5];
      end
      2: begin            // shared endpoint
        c[4] = c[2]; c[5] = c[3];
      end
      3: begin            // nearly parallel, small offset
        c[4] = c[0] + $urandom_range(0, 3); c[5] = c[1];
        c[6] = c[2]; c[7] = c[3] + $urandom_range(0, 3);
        if (c[4] > CoordMax) c[4] = CoordMax;
        if (c[7] > CoordMax) c[7] = CoordMax;
      end
      default: ;
    endcase
    return pack_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  // Present one pair and hold it until the transfer
  task automatic send_pair(logic [InW-1:0] pair, bit typed, point_t want);
    typed_due.insert(typed_due.size(), typed);
    typed_point.insert(typed_point.size(), want);
    s_axis_tdata  <= pair;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop valid for a random gap, mostly short, now and then long
  task automatic sender_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
    if ($urandom_range(0, 49) == 0) g = $urandom_range(10, 40);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Raise valid and hold it until the transfer; the caller drops it afterwards
  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Let the pipeline drain completely before touching the registers
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (points_due.size() != 0 || typed_due.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Capture on s_axis: predict, or take the typed expectation
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (typed_due.pop_front()) points_due.insert(points_due.size(), typed_point.pop_front());
      else begin
        void'(typed_point.pop_front());
        points_due.insert(points_due.size(), predict_point(s_axis_tdata));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgCrossTol) cross_tol <= cfg_data_i[CrossTolW-1:0];
      else if (cfg_index_i == CfgParamTol) param_tol <= cfg_data_i[ParamTolW-1:0];
    end
  end

  // Check on m_axis against the oldest expectation
  always @(posedge clk_i) begin
    point_t want;
    point_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = point_t'(m_axis_tdata[2 + 2 * CW - 1:0]);
      if (points_due.size() == 0) begin
        $error("unexpected result transfer: status %0d x %0d y %0d",
               got.status, got.x, got.y);
        errors++;
      end else begin
        want = points_due.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          errors++;
        end
        if (got.x !== want.x) begin
          $error("cross_x: expected %0d, actual %0d", want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $error("cross_y: expected %0d, actual %0d", want.y, got.y);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure: runs of ready, short stalls, rare long ones
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      n = $urandom_range(1, 40);
      repeat (n) @(posedge clk_i);
      if (!rx_hold_ready) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(0, 19) == 0 ? $urandom_range(15, 60) : $urandom_range(1, 4);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin
    row_t rows[$];
    point_t nopt;
    longint unsigned ct [5];
    longint unsigned pt [5];
    nopt = '{status: ST_INTERSECT, x: '0, y: '0};
    ct = '{429, 0, 1048575, 0, 37};
    pt = '{2, 0, 65535, 0, 700};
    ct[3] = $urandom_range(0, 1048575);
    pt[3] = $urandom_range(0, 65535);

    // Directed table: typed expectations only where plain by inspection
    rows.insert(rows.size(), row_t'{pack_pair(0, 0, 0, 0, 0, 0, 0, 0), 1,
                     '{status: ST_COLLINEAR, x: '0, y: '0}});
    rows.insert(rows.size(), row_t'{pack_pair(CoordMax, CoordMax, CoordMax, CoordMax,
                               CoordMax, CoordMax, CoordMax, CoordMax), 1,
                     '{status: ST_COLLINEAR, x: '0, y: '0}});
    rows.insert(rows.size(),
                row_t'{pack_pair(0, 0, CoordOne, 0, 0, CoordOne, CoordOne, CoordOne), 1,
                       '{status: ST_PARALLEL, x: '0, y: '0}});
    rows.insert(rows.size(),
                row_t'{pack_pair(0, 0, CoordOne, CoordOne, 0, CoordOne, CoordOne, 0), 1,
                       '{status: ST_INTERSECT, x: CW'(32768), y: CW'(32768)}});
    rows.insert(rows.size(), row_t'{pack_pair(0, 0, 100, 100, 0, CoordOne, CoordOne, 0), 1,
                     '{status: ST_OUTSIDE, x: '0, y: '0}});
    // overlapping collinear on the diagonal
    rows.insert(rows.size(),
                row_t'{pack_pair(0, 0, 40000, 40000, 20000, 20000, CoordOne, CoordOne),
                       0, nopt});
    // diagonal over the full field: tie rounding near 1.0
    rows.insert(rows.size(),
                row_t'{pack_pair(0, 0, CoordMax, CoordMax, 0, CoordMax, CoordMax, 0),
                       0, nopt});
    // crossing beyond 1.0: saturate high
    rows.insert(rows.size(),
                row_t'{pack_pair(0, 70000, CoordMax, 70000, 100000, 0, 100000, CoordMax),
                       0, nopt});
    // touching at an endpoint
    rows.insert(rows.size(),
                row_t'{pack_pair(0, 0, 30000, 30000, 30000, 30000, CoordOne, 0), 0, nopt});
    // just past the end, within and outside slack
    rows.insert(rows.size(),
                row_t'{pack_pair(0, 0, 65535, 0, CoordOne, 1, CoordOne, CoordOne), 0, nopt});
    rows.insert(rows.size(), row_t'{pack_pair(0, 0, 3, 1, 1, 0, 2, 1), 0, nopt});
    // reversed directions, odd coordinates
    rows.insert(rows.size(),
                row_t'{pack_pair(CoordOne, CoordOne, 1, 3, 5, 60001, 65001, 7), 0, nopt});
    rows.insert(rows.size(),
                row_t'{pack_pair(CoordMax, 0, 0, CoordMax, 0, 0, CoordMax, CoordMax),
                       0, nopt});
    rows.insert(rows.size(), row_t'{pack_pair(1, 1, 2, 2, 1, 2, 2, 1), 0, nopt});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_pair(rows[i].pair, rows[i].typed, rows[i].want);
      sender_gap();
    end
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CfgCrossTol, CfgDataW'(ct[ph]));
      write_reg(CfgParamTol, CfgDataW'(pt[ph]));
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
      for (int k = 0; k < RandPerPhase; k++) begin
        send_pair(rand_pair(), 0, nopt);
        // hold off once until everything in flight has come out
        if (ph == 1 && k == RandPerPhase / 2) drain();
        // a stretch with no gaps and the output always ready
        if (ph == 2 && k == 100) rx_hold_ready = 1'b1;
        if (ph == 2 && k == 200) rx_hold_ready = 1'b0;
        if (!(ph == 2 && k >= 100 && k < 200)) sender_gap();
      end
      drain();
    end

    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
